>>> rtl/sm3_pkg.sv
`default_nettype none

package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  bytes_valid;
        logic        last;
    } sm3_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } sm3_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } sm3_state_t;

    // what the block in the window is
    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_PAD_FIRST,
        JOB_FINAL
    } sm3_job_t;

    localparam logic [31:0] SM3_T_LOW  = 32'h79cc4519;
    localparam logic [31:0] SM3_T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  SM3_PAD    = 8'h80;

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

endpackage

`default_nettype wire

>>> rtl/sm3_hash_engine.sv
// A beat that does not fill the block is only written into the block buffer; a
// beat that fills it starts 64 rounds of the single round unit, then a fold.
// Last beat: a padding step, then rounds and a fold per padded block (one or
// two), then eight digest beats. A new beat is taken only while idle.
// Reset (async, active low) loads the IV and clears the length and fill.
// Digest beats cannot be stalled.
`default_nettype none

module sm3_hash_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sm3_pkg::sm3_in_t  msg,
    output logic                   busy,
    output logic                   strobe,
    output sm3_pkg::sm3_out_t      digest
);

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] j);
        logic [31:0] t;
        logic [63:0] tmp;
        t   = (j[5:4] == 2'b00) ? sm3_pkg::SM3_T_LOW : sm3_pkg::SM3_T_HIGH;
        tmp = {t, t} << j[4:0];
        return tmp[63:32];
    endfunction

    sm3_pkg::sm3_state_t state_reg, state_next;
    sm3_pkg::sm3_job_t   job_reg, job_next;

    logic [31:0] win_reg   [16];
    logic [31:0] win_next  [16];
    logic [31:0] v_reg     [8];
    logic [31:0] v_next    [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next[8];

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [31:0] pend_word_reg, pend_word_next;
    logic [2:0]  pend_cnt_reg, pend_cnt_next;

    logic        accept;
    logic [2:0]  nb;
    logic [6:0]  sum;
    logic        overflow;
    logic [6:0]  n_written;
    logic        wr_en;
    logic [31:0] src_word;
    logic [2:0]  src_cnt;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wn;
    logic [31:0] fold [8];

    assign accept    = start && (state_reg == sm3_pkg::ST_IDLE);
    assign nb        = (msg.bytes_valid > 3'd4) ? 3'd4 : msg.bytes_valid;
    assign sum       = {1'b0, fill_reg} + {4'b0, nb};
    assign overflow  = sum[6];
    assign n_written = 7'd64 - {1'b0, fill_reg};
    assign wr_en     = accept ||
                       (state_reg == sm3_pkg::ST_FOLD && job_reg == sm3_pkg::JOB_DATA);
    assign src_word  = (state_reg == sm3_pkg::ST_IDLE) ? msg.message_word : pend_word_reg;
    assign src_cnt   = (state_reg == sm3_pkg::ST_IDLE) ? nb : pend_cnt_reg;

    // round unit
    assign a12 = rotl(v_reg[0], 12);
    assign ss1 = rotl(a12 + v_reg[4] + round_const(cnt_reg), 7);
    assign ss2 = ss1 ^ a12;
    assign ff  = (cnt_reg[5:4] == 2'b00) ? (v_reg[0] ^ v_reg[1] ^ v_reg[2]) :
                 ((v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]));
    assign gg  = (cnt_reg[5:4] == 2'b00) ? (v_reg[4] ^ v_reg[5] ^ v_reg[6]) :
                 ((v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]));
    assign tt1 = ff + v_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
    assign tt2 = gg + v_reg[7] + ss1 + win_reg[0];
    assign wn  = p1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 15)) ^
                 rotl(win_reg[3], 7) ^ win_reg[10];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            fold[k] = chain_reg[k] ^ v_reg[k];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (overflow)
                        state_next = sm3_pkg::ST_ROUND;
                    else if (msg.last)
                        state_next = sm3_pkg::ST_PAD;
                end
            end
            sm3_pkg::ST_ROUND:
            begin
                if (cnt_reg == 6'd63)
                    state_next = sm3_pkg::ST_FOLD;
            end
            sm3_pkg::ST_FOLD:
            begin
                unique case (job_reg)
                    sm3_pkg::JOB_DATA:
                        state_next = last_reg ? sm3_pkg::ST_PAD : sm3_pkg::ST_IDLE;
                    sm3_pkg::JOB_PAD_FIRST:
                        state_next = sm3_pkg::ST_ROUND;
                    sm3_pkg::JOB_FINAL:
                        state_next = sm3_pkg::ST_OUT;
                    default:
                        state_next = sm3_pkg::ST_IDLE;
                endcase
            end
            sm3_pkg::ST_PAD:
                state_next = sm3_pkg::ST_ROUND;
            sm3_pkg::ST_OUT:
            begin
                if (cnt_reg[2:0] == 3'd7)
                    state_next = sm3_pkg::ST_IDLE;
            end
            default:
                state_next = sm3_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy               = (state_reg != sm3_pkg::ST_IDLE);
        strobe             = (state_reg == sm3_pkg::ST_OUT);
        digest.digest_word = chain_reg[0];
        digest.digest_last = (cnt_reg[2:0] == 3'd7);
    end

    always_comb
    begin
        logic [5:0] pos;
        logic [5:0] off;

        win_next       = win_reg;
        v_next         = v_reg;
        chain_next     = chain_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        job_next       = job_reg;
        last_next      = last_reg;
        pend_word_next = pend_word_reg;
        pend_cnt_next  = pend_cnt_reg;
        pos            = '0;
        off            = '0;

        // byte lanes into the block buffer
        if (wr_en)
        begin
            for (int i = 0; i < 16; i++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    pos = 6'(i * 4 + l);
                    off = pos - fill_reg;
                    if (pos >= fill_reg && off < {3'b0, src_cnt})
                        win_next[i][8 * (3 - l) +: 8] = src_word[8 * (3 - off[1:0]) +: 8];
                end
            end
        end

        unique case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    len_next       = len_reg + {58'b0, nb, 3'b0};
                    last_next      = msg.last;
                    pend_word_next = msg.message_word << {n_written[2:0], 3'b0};
                    pend_cnt_next  = sum[2:0];
                    fill_next      = overflow ? 6'd0 : sum[5:0];
                    if (overflow)
                    begin
                        job_next = sm3_pkg::JOB_DATA;
                        v_next   = chain_reg;
                        cnt_next = '0;
                    end
                end
            end
            sm3_pkg::ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = wn;
                v_next[3]    = v_reg[2];
                v_next[2]    = rotl(v_reg[1], 9);
                v_next[1]    = v_reg[0];
                v_next[0]    = tt1;
                v_next[7]    = v_reg[6];
                v_next[6]    = rotl(v_reg[5], 19);
                v_next[5]    = v_reg[4];
                v_next[4]    = p0(tt2);
                cnt_next     = cnt_reg + 6'd1;
            end
            sm3_pkg::ST_FOLD:
            begin
                chain_next = fold;
                cnt_next   = '0;
                case (job_reg)
                    sm3_pkg::JOB_DATA:
                        fill_next = {3'b0, pend_cnt_reg};
                    sm3_pkg::JOB_PAD_FIRST:
                    begin
                        for (int i = 0; i < 14; i++)
                        begin
                            win_next[i] = '0;
                        end
                        win_next[14] = len_reg[63:32];
                        win_next[15] = len_reg[31:0];
                        v_next       = fold;
                        job_next     = sm3_pkg::JOB_FINAL;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sm3_pkg::ST_PAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        pos = 6'(i * 4 + l);
                        if (pos == fill_reg)
                            win_next[i][8 * (3 - l) +: 8] = sm3_pkg::SM3_PAD;
                        else if (pos > fill_reg)
                            win_next[i][8 * (3 - l) +: 8] = '0;
                    end
                end
                if (fill_reg[5:3] == 3'b111)
                begin
                    job_next = sm3_pkg::JOB_PAD_FIRST;
                end
                else
                begin
                    win_next[14] = len_reg[63:32];
                    win_next[15] = len_reg[31:0];
                    job_next     = sm3_pkg::JOB_FINAL;
                end
                v_next   = chain_reg;
                cnt_next = '0;
            end
            sm3_pkg::ST_OUT:
            begin
                for (int k = 0; k < 7; k++)
                begin
                    chain_next[k] = chain_reg[k + 1];
                end
                chain_next[7] = chain_reg[0];
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    chain_next = sm3_pkg::SM3_IV;
                    fill_next  = '0;
                    len_next   = '0;
                    last_next  = 1'b0;
                    cnt_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sm3_pkg::ST_IDLE;
            job_reg      <= sm3_pkg::JOB_DATA;
            fill_reg     <= '0;
            len_reg      <= '0;
            cnt_reg      <= '0;
            last_reg     <= 1'b0;
            pend_cnt_reg <= '0;
            for (int k = 0; k < 8; k++)
            begin
                chain_reg[k] <= sm3_pkg::SM3_IV[k];
            end
        end
        else
        begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
            pend_cnt_reg <= pend_cnt_next;
            chain_reg    <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        v_reg         <= v_next;
        pend_word_reg <= pend_word_next;
    end

endmodule

`default_nettype wire

>>> rtl/sm3_chk.sv
`default_nettype none

module sm3_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire sm3_pkg::sm3_in_t  msg,
    input wire logic              busy,
    input wire logic              strobe,
    input wire sm3_pkg::sm3_out_t digest
);

    // digest beats only come out of a busy engine
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> busy)
        else $error("digest beat while idle");

    // eight digest beats run back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !digest.digest_last |=> strobe)
        else $error("digest beats not contiguous");

    // engine is free right after the final digest beat
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && digest.digest_last |=> !busy && !strobe)
        else $error("engine not idle after final digest beat");

    // a non-final beat never yields a digest beat next
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !msg.last |=> !strobe)
        else $error("digest beat without final message beat");

endmodule

bind sm3_hash_engine sm3_chk u_sm3_chk (.*);

`default_nettype wire
